>>> hw/rtl/csv_tokenizer_with_escapes_defines.svh
// Assertion macros shared by the tokenizer modules.
`ifndef CSV_TOKENIZER_WITH_ESCAPES_DEFINES_SVH
`define CSV_TOKENIZER_WITH_ESCAPES_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csvt: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CSVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csvt: next-cycle check failed");

`endif

>>> hw/rtl/csvt_pkg.sv
package csvt_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_CELL = 2'd1;
	localparam logic [1:0] KIND_ROW  = 2'd2;

	// Characters of interest.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_LOW_C  = 8'h63;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [7:0] COLOR_CODE_RESET = 8'd28;

	localparam int MAX_RESULTS = 3;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_OPEN,
		ESC_HEX0,
		ESC_HEX1
	} esc_phase_t;

	// All results caused by one input item.
	typedef struct packed {
		logic [1:0]       count;
		logic [2:0][1:0]  kind;
		logic [2:0][7:0]  data;
	} bundle_t;

	function automatic bundle_t push_res(bundle_t bun, logic [1:0] kind, logic [7:0] data);
		bundle_t r;
		r = bun;
		if (bun.count != 2'(MAX_RESULTS)) begin
			r.kind[bun.count] = kind;
			r.data[bun.count] = data;
			r.count = bun.count + 2'd1;
		end
		return r;
	endfunction

	// Emits a gathered hex value if a hex escape is open and the value is not zero.
	function automatic bundle_t hex_flush(bundle_t bun, esc_phase_t ep, logic [7:0] hv);
		bundle_t r;
		r = bun;
		if ((ep == ESC_HEX0 || ep == ESC_HEX1) && hv != 8'd0) begin
			r = push_res(bun, KIND_BYTE, hv);
		end
		return r;
	endfunction

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/csvt_in_if.sv
interface csvt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_buffer;

	modport source (output valid, output text_byte, output end_of_buffer, input ready);
	modport sink (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

>>> hw/rtl/csvt_out_if.sv
interface csvt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] cell_byte;
	logic       last_of_run;

	modport source (output valid, output item_kind, output cell_byte, output last_of_run,
		input ready);
	modport sink (input valid, input item_kind, input cell_byte, input last_of_run,
		output ready);
endinterface

>>> hw/rtl/csv_tokenizer_with_escapes.sv
// CSV tokenizer with backslash-escape decoding.
// The text_in channel takes one raw byte of a CSV buffer per item, with
// end_of_buffer set on the final byte; that byte is processed and then the
// tokenizer flushes any open cell or row and returns to its reset state.
// The token_out channel gives decoded cell bytes, end-of-cell marks and
// end-of-row marks; last_of_run flags the final result caused by an input item.
// Each input byte causes between zero and three results. The front stage
// decodes a byte in the cycle it is accepted; its results go through the
// queue and the output register. One byte is taken every cycle while the
// queue is not full; the single output register issues one result per cycle
// while the receiver is ready, so a byte with two or three results holds it
// longer and the bundle queue of QUEUE_DEPTH entries absorbs the difference.
// When the receiver stalls, the output register holds its result and the
// queue fills; text_in.ready falls only once the queue is full.
// Reset clears the tokenizer state, empties the queue and sets the colour code
// register to 28; cfg_we writes that register and should be used while idle.
module csv_tokenizer_with_escapes #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	csvt_in_if.sink     text_in,
	csvt_out_if.source  token_out
);

	// Bundles of results travel from front to back through a short queue.
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_head_valid;
	csvt_pkg::bundle_t  q_push_data;
	csvt_pkg::bundle_t  q_head_data;

	// The front stage holds the quote and escape state and the colour register.
	csvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.text_in   (text_in),
		.full      (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	csvt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head_data)
	);

	// The back stage serialises each bundle into single results.
	csvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_data  (q_head_data),
		.pop        (q_pop),
		.token_out  (token_out)
	);

endmodule

>>> hw/rtl/csvt_front.sv
module csvt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	csvt_in_if.sink            text_in,
	input  logic               full,
	output logic               push,
	output csvt_pkg::bundle_t  push_data
);

	logic [7:0]            color_code_q;
	logic                  in_quotes_q;
	logic                  quote_pending_q;
	logic                  cell_has_chars_q;
	logic                  row_has_cells_q;
	logic                  cell_truncated_q;
	csvt_pkg::esc_phase_t  escape_phase_q;
	logic [7:0]            hex_value_q;

	logic                  iq, qp, chc, rhc, ct;
	csvt_pkg::esc_phase_t  ep;
	logic [7:0]            hv;
	csvt_pkg::bundle_t     bun;
	logic                  accept;

	assign text_in.ready = !full;
	assign accept = text_in.valid && text_in.ready;

	always_comb begin
		logic        handled;
		logic        do_push;
		logic        do_end;
		logic        end_row;
		logic [7:0]  b;
		logic [4:0]  hd;
		b = text_in.text_byte;
		hd = csvt_pkg::hex_digit(b);
		iq = in_quotes_q;
		qp = quote_pending_q;
		chc = cell_has_chars_q;
		rhc = row_has_cells_q;
		ct = cell_truncated_q;
		ep = escape_phase_q;
		hv = hex_value_q;
		bun = '0;
		handled = 1'b0;
		do_push = 1'b0;
		do_end = 1'b0;
		end_row = 1'b0;

		// A quote held back from the previous item: doubled quote or close.
		if (qp) begin
			qp = 1'b0;
			if (b == csvt_pkg::CH_QUOTE) begin
				do_push = 1'b1;
				handled = 1'b1;
			end else begin
				iq = 1'b0;
			end
		end

		if (!handled) begin
			priority if (b == csvt_pkg::CH_QUOTE) begin
				if (iq) begin
					if (text_in.end_of_buffer) begin
						iq = 1'b0;
					end else begin
						qp = 1'b1;
					end
				end else if (!chc) begin
					iq = 1'b1;
				end
			end else if (b == csvt_pkg::CH_COMMA) begin
				if (!iq) begin
					do_end = 1'b1;
				end else begin
					do_push = 1'b1;
				end
			end else if (b == csvt_pkg::CH_CR) begin
				do_push = 1'b0;
			end else if (b == csvt_pkg::CH_LF && !iq) begin
				do_end = 1'b1;
				end_row = 1'b1;
			end else begin
				do_push = 1'b1;
			end
		end

		// Escape decoder for one raw cell byte.
		if (do_push) begin
			chc = 1'b1;
			if (!ct) begin
				if (b == csvt_pkg::CH_NUL) begin
					bun = csvt_pkg::hex_flush(bun, ep, hv);
					ep = csvt_pkg::ESC_NONE;
					hv = 8'd0;
					ct = 1'b1;
				end else if (ep == csvt_pkg::ESC_OPEN) begin
					ep = csvt_pkg::ESC_NONE;
					priority if (b == csvt_pkg::CH_LOW_N) begin
						bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_BYTE, csvt_pkg::CH_LF);
					end else if (b == csvt_pkg::CH_LOW_R) begin
						bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR);
					end else if (b == csvt_pkg::CH_LOW_T) begin
						bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_BYTE, csvt_pkg::CH_TAB);
					end else if (b == csvt_pkg::CH_LOW_C) begin
						bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_BYTE, color_code_q);
					end else if (b == csvt_pkg::CH_LOW_X) begin
						ep = csvt_pkg::ESC_HEX0;
						hv = 8'd0;
					end else if (b == csvt_pkg::CH_LF) begin
						ep = csvt_pkg::ESC_NONE;
					end else begin
						bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_BYTE, b);
					end
				end else begin
					handled = 1'b0;
					if (ep == csvt_pkg::ESC_HEX0 || ep == csvt_pkg::ESC_HEX1) begin
						if (hd[4]) begin
							hv = {hv[3:0], hd[3:0]};
							if (ep == csvt_pkg::ESC_HEX1) begin
								bun = csvt_pkg::hex_flush(bun, ep, hv);
								ep = csvt_pkg::ESC_NONE;
								hv = 8'd0;
							end else begin
								ep = csvt_pkg::ESC_HEX1;
							end
							handled = 1'b1;
						end else begin
							bun = csvt_pkg::hex_flush(bun, ep, hv);
							ep = csvt_pkg::ESC_NONE;
							hv = 8'd0;
						end
					end
					if (!handled) begin
						if (b == csvt_pkg::CH_BSLASH) begin
							ep = csvt_pkg::ESC_OPEN;
						end else begin
							bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_BYTE, b);
						end
					end
				end
			end
		end

		if (do_end) begin
			bun = csvt_pkg::hex_flush(bun, ep, hv);
			ep = csvt_pkg::ESC_NONE;
			hv = 8'd0;
			bun = csvt_pkg::push_res(bun, end_row ? csvt_pkg::KIND_ROW : csvt_pkg::KIND_CELL,
				8'd0);
			chc = 1'b0;
			ct = 1'b0;
			rhc = !end_row;
		end

		// Flush on the last byte of the buffer, then back to the reset state.
		if (text_in.end_of_buffer) begin
			if (chc || rhc) begin
				bun = csvt_pkg::hex_flush(bun, ep, hv);
				bun = csvt_pkg::push_res(bun, csvt_pkg::KIND_ROW, 8'd0);
			end
			iq = 1'b0;
			qp = 1'b0;
			chc = 1'b0;
			rhc = 1'b0;
			ct = 1'b0;
			ep = csvt_pkg::ESC_NONE;
			hv = 8'd0;
		end
	end

	assign push = accept && (bun.count != 2'd0);
	assign push_data = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_code_q <= csvt_pkg::COLOR_CODE_RESET;
			in_quotes_q <= 1'b0;
			quote_pending_q <= 1'b0;
			cell_has_chars_q <= 1'b0;
			row_has_cells_q <= 1'b0;
			cell_truncated_q <= 1'b0;
			escape_phase_q <= csvt_pkg::ESC_NONE;
			hex_value_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				color_code_q <= cfg_wdata;
			end
			if (accept) begin
				in_quotes_q <= iq;
				quote_pending_q <= qp;
				cell_has_chars_q <= chc;
				row_has_cells_q <= rhc;
				cell_truncated_q <= ct;
				escape_phase_q <= ep;
				hex_value_q <= hv;
			end
		end
	end

endmodule

>>> hw/rtl/csvt_queue.sv
`include "csv_tokenizer_with_escapes_defines.svh"

module csvt_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csvt_pkg::bundle_t  push_data,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output csvt_pkg::bundle_t  head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	csvt_pkg::bundle_t  entries_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CSVT_ASSERT_IMP(a_queue_bounded, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`CSVT_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, count_q != '0)
	`CSVT_ASSERT_NXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

>>> hw/rtl/csvt_back.sv
`include "csv_tokenizer_with_escapes_defines.svh"

module csvt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  csvt_pkg::bundle_t  head_data,
	output logic               pop,
	csvt_out_if.source         token_out
);

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [1:0]  idx_q;

	logic        load;
	logic        is_last;

	assign load = !out_valid_q || token_out.ready;
	assign is_last = (idx_q == head_data.count - 2'd1);
	assign pop = load && head_valid && is_last;

	assign token_out.valid = out_valid_q;
	assign token_out.item_kind = out_kind_q;
	assign token_out.cell_byte = out_byte_q;
	assign token_out.last_of_run = out_last_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_kind_q <= head_data.kind[idx_q];
			out_byte_q <= head_data.data[idx_q];
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	`CSVT_ASSERT_IMP(a_idx_in_bundle, clk, arst_n, head_valid, idx_q < head_data.count)
	`CSVT_ASSERT_IMP(a_mark_has_no_byte, clk, arst_n, out_valid_q && out_kind_q != csvt_pkg::KIND_BYTE, out_byte_q == 8'd0)

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the CSV tokenizer with backslash-escape decoding.
module tb_top;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 11;
	// Cycles after the last expected token before the block is taken as idle.
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	// Cycles without any accepted item on either channel before giving up.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;
	localparam int ITEMS_PER_PHASE = 70;

	// One token as it appears on the output channel.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} tok_t;

	// One raw text item with its end-of-buffer flag.
	typedef struct packed {
		logic [7:0] txt;
		logic       eob;
	} txt_t;

	// A row of the directed table. When pinned is set, the n_pinned tokens
	// given in the row are expected instead of those of the predictor.
	typedef struct packed {
		logic [7:0] txt;
		logic       eob;
		logic       pinned;
		logic [1:0] n_pinned;
		tok_t       r0;
		tok_t       r1;
		tok_t       r2;
	} row_t;

	localparam tok_t NO_TOK = '0;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	csvt_in_if  txt_in ();
	csvt_out_if tok_out ();

	csv_tokenizer_with_escapes i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.text_in   (txt_in),
		.token_out (tok_out)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Tokenizer predictor: our own copy of the quote state, the escape
	// decoder and the colour code register.
	// ------------------------------------------------------------------
	logic                 tq_in_quotes;
	logic                 tq_pending;
	logic                 tq_cell_has;
	logic                 tq_row_has;
	logic                 tq_trunc;
	csvt_pkg::esc_phase_t tq_esc;
	logic [7:0]           tq_hex;
	logic [7:0]           colour_code;

	// Tokens caused by the item being predicted, and the store of tokens
	// still awaited from the block.
	tok_t run_toks [$];
	tok_t tok_expected [$];

	int mismatches;

	task automatic clear_tokenizer();
		tq_in_quotes = 1'b0;
		tq_pending   = 1'b0;
		tq_cell_has  = 1'b0;
		tq_row_has   = 1'b0;
		tq_trunc     = 1'b0;
		tq_esc       = csvt_pkg::ESC_NONE;
		tq_hex       = 8'd0;
	endtask

	function automatic int hex_nibble(logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b) - int'("0");
		if (b >= "a" && b <= "f")
			return int'(b) - int'("a") + 10;
		if (b >= "A" && b <= "F")
			return int'(b) - int'("A") + 10;
		return -1;
	endfunction

	// No item ever yields more than three tokens; anything beyond is lost.
	task automatic emit_tok(logic [1:0] k, logic [7:0] d);
		tok_t t;
		if (run_toks.size() < csvt_pkg::MAX_RESULTS) begin
			t.kind = k;
			t.data = d;
			t.last = 1'b0;
			run_toks.push_back(t);
		end
	endtask

	// An open hex escape gives its value, unless that value is zero.
	task automatic close_escape_seq();
		if ((tq_esc == csvt_pkg::ESC_HEX0 || tq_esc == csvt_pkg::ESC_HEX1) && tq_hex != 8'd0)
			emit_tok(csvt_pkg::KIND_BYTE, tq_hex);
		tq_esc = csvt_pkg::ESC_NONE;
		tq_hex = 8'd0;
	endtask

	task automatic decode_cell_byte(logic [7:0] b);
		int nib;
		if (tq_trunc)
			return;
		// A raw zero ends any escape and silences the rest of the cell.
		if (b == csvt_pkg::CH_NUL) begin
			close_escape_seq();
			tq_trunc = 1'b1;
			return;
		end
		if (tq_esc == csvt_pkg::ESC_OPEN) begin
			tq_esc = csvt_pkg::ESC_NONE;
			case (b)
				csvt_pkg::CH_LOW_N: emit_tok(csvt_pkg::KIND_BYTE, csvt_pkg::CH_LF);
				csvt_pkg::CH_LOW_R: emit_tok(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR);
				csvt_pkg::CH_LOW_T: emit_tok(csvt_pkg::KIND_BYTE, csvt_pkg::CH_TAB);
				csvt_pkg::CH_LOW_C: emit_tok(csvt_pkg::KIND_BYTE, colour_code);
				csvt_pkg::CH_LOW_X: begin
					tq_esc = csvt_pkg::ESC_HEX0;
					tq_hex = 8'd0;
				end
				csvt_pkg::CH_LF: ;
				default: emit_tok(csvt_pkg::KIND_BYTE, b);
			endcase
			return;
		end
		if (tq_esc == csvt_pkg::ESC_HEX0 || tq_esc == csvt_pkg::ESC_HEX1) begin
			nib = hex_nibble(b);
			if (nib >= 0) begin
				tq_hex = {tq_hex[3:0], 4'(nib)};
				if (tq_esc == csvt_pkg::ESC_HEX1)
					close_escape_seq();
				else
					tq_esc = csvt_pkg::ESC_HEX1;
				return;
			end
			// Any other byte ends the hex escape and is then decoded as usual.
			close_escape_seq();
		end
		if (b == csvt_pkg::CH_BSLASH)
			tq_esc = csvt_pkg::ESC_OPEN;
		else
			emit_tok(csvt_pkg::KIND_BYTE, b);
	endtask

	task automatic enter_cell_byte(logic [7:0] b);
		tq_cell_has = 1'b1;
		decode_cell_byte(b);
	endtask

	task automatic close_cell(logic [1:0] k);
		close_escape_seq();
		emit_tok(k, 8'd0);
		tq_cell_has = 1'b0;
		tq_trunc    = 1'b0;
	endtask

	// Works out the tokens that one accepted text item causes.
	task automatic tokenize_byte(logic [7:0] b, logic eob);
		logic done;
		done = 1'b0;
		run_toks.delete();
		// A quote seen inside quotes waits one item: a second quote makes a
		// literal quote, anything else closes the quoted section.
		if (tq_pending) begin
			tq_pending = 1'b0;
			if (b == csvt_pkg::CH_QUOTE) begin
				enter_cell_byte(csvt_pkg::CH_QUOTE);
				done = 1'b1;
			end else begin
				tq_in_quotes = 1'b0;
			end
		end
		if (!done) begin
			if (b == csvt_pkg::CH_QUOTE) begin
				if (tq_in_quotes) begin
					if (eob)
						tq_in_quotes = 1'b0;
					else
						tq_pending = 1'b1;
				end else if (!tq_cell_has) begin
					tq_in_quotes = 1'b1;
				end
				// A stray quote in a cell that already has content is dropped.
			end else if (b == csvt_pkg::CH_COMMA) begin
				if (!tq_in_quotes) begin
					close_cell(csvt_pkg::KIND_CELL);
					tq_row_has = 1'b1;
				end else begin
					enter_cell_byte(b);
				end
			end else if (b == csvt_pkg::CH_CR) begin
				// Carriage returns are always dropped.
			end else if (b == csvt_pkg::CH_LF && !tq_in_quotes) begin
				close_cell(csvt_pkg::KIND_ROW);
				tq_row_has = 1'b0;
			end else begin
				enter_cell_byte(b);
			end
		end
		// The last item of a buffer flushes any open cell or row.
		if (eob) begin
			if (tq_cell_has || tq_row_has)
				close_cell(csvt_pkg::KIND_ROW);
			clear_tokenizer();
		end
		if (run_toks.size() > 0)
			run_toks[run_toks.size() - 1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps.
	// ------------------------------------------------------------------
	int burst_left;

	task automatic send_txt(logic [7:0] b, logic eob);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			// Now and then a long burst with no gaps at all.
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
			txt_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		txt_in.valid         <= 1'b1;
		txt_in.text_byte     <= b;
		txt_in.end_of_buffer <= eob;
		@(posedge clk);
		while (!txt_in.ready)
			@(posedge clk);
	endtask

	// Sends one item and records the tokens it should cause. The prediction
	// is made in the step of acceptance, before any of its tokens can appear.
	task automatic feed_row(row_t row);
		tok_t pinned_toks [3];
		send_txt(row.txt, row.eob);
		tokenize_byte(row.txt, row.eob);
		if (row.pinned) begin
			pinned_toks[0] = row.r0;
			pinned_toks[1] = row.r1;
			pinned_toks[2] = row.r2;
			for (int k = 0; k < int'(row.n_pinned); k++)
				tok_expected.push_back(pinned_toks[k]);
		end else begin
			foreach (run_toks[k])
				tok_expected.push_back(run_toks[k]);
		end
	endtask

	// Lets the block run dry: every token awaited has come and a few more
	// cycles have passed for items that cause no token.
	task automatic drain_tokenizer();
		txt_in.valid <= 1'b0;
		burst_left = 0;
		while (tok_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_colour_code(logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		colour_code = v;
	endtask

	// ------------------------------------------------------------------
	// Random text: buffers of rows and cells, mostly well formed, with
	// quoted cells, escapes of every kind and a little noise.
	// ------------------------------------------------------------------
	txt_t txt_q [$];

	task automatic add_txt(logic [7:0] b);
		txt_t t;
		t.txt = b;
		t.eob = 1'b0;
		txt_q.push_back(t);
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'("0" + v);
		return ($urandom_range(0, 1) == 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	task automatic gen_piece(bit quoted);
		case ($urandom_range(0, 17))
			0, 1, 2, 3, 4: add_txt(8'("a" + $urandom_range(0, 25)));
			5: begin
				add_txt(csvt_pkg::CH_BSLASH);
				case ($urandom_range(0, 3))
					0: add_txt(csvt_pkg::CH_LOW_N);
					1: add_txt(csvt_pkg::CH_LOW_R);
					2: add_txt(csvt_pkg::CH_LOW_T);
					default: add_txt(csvt_pkg::CH_LOW_C);
				endcase
			end
			6: begin
				add_txt(csvt_pkg::CH_BSLASH);
				add_txt(csvt_pkg::CH_LOW_X);
				add_txt(hex_char());
				add_txt(hex_char());
			end
			7: begin
				// A short hex escape, ended by whatever follows.
				add_txt(csvt_pkg::CH_BSLASH);
				add_txt(csvt_pkg::CH_LOW_X);
				add_txt(hex_char());
			end
			8: begin
				add_txt(csvt_pkg::CH_BSLASH);
				add_txt(csvt_pkg::CH_LOW_X);
				add_txt("0");
				add_txt("0");
			end
			9: begin
				add_txt(csvt_pkg::CH_BSLASH);
				add_txt(8'($urandom_range(8'h20, 8'h7E)));
			end
			10: begin
				if (quoted) begin
					add_txt(csvt_pkg::CH_QUOTE);
					add_txt(csvt_pkg::CH_QUOTE);
				end else begin
					add_txt(csvt_pkg::CH_CR);
				end
			end
			11: begin
				// Escaped or plain newline, which only stays in the cell in quotes.
				if (quoted) begin
					if ($urandom_range(0, 1) == 0)
						add_txt(csvt_pkg::CH_BSLASH);
					add_txt(csvt_pkg::CH_LF);
				end else begin
					add_txt(8'("0" + $urandom_range(0, 9)));
				end
			end
			12: begin
				if (quoted)
					add_txt(csvt_pkg::CH_COMMA);
				else
					add_txt(csvt_pkg::CH_QUOTE);
			end
			13: add_txt(csvt_pkg::CH_CR);
			14: add_txt(($urandom_range(0, 2) == 0) ? csvt_pkg::CH_NUL : 8'("k"));
			15: add_txt(csvt_pkg::CH_BSLASH);
			default: add_txt(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic gen_cell();
		bit quoted;
		int n;
		quoted = ($urandom_range(0, 2) == 0);
		if (quoted)
			add_txt(csvt_pkg::CH_QUOTE);
		n = $urandom_range(0, 4);
		repeat (n) gen_piece(quoted);
		if (quoted)
			add_txt(csvt_pkg::CH_QUOTE);
		if ($urandom_range(0, 15) == 0)
			add_txt(csvt_pkg::CH_QUOTE);
	endtask

	task automatic gen_buffer();
		int start;
		int rows;
		int cells;
		start = txt_q.size();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 8)) add_txt(8'($urandom_range(0, 255)));
		end else begin
			rows = $urandom_range(1, 3);
			for (int r = 0; r < rows; r++) begin
				cells = $urandom_range(1, 3);
				for (int c = 0; c < cells; c++) begin
					gen_cell();
					if (c < cells - 1)
						add_txt(csvt_pkg::CH_COMMA);
				end
				// The last row is left open now and then so the flush closes it.
				if (r < rows - 1 || $urandom_range(0, 1) == 0) begin
					if ($urandom_range(0, 3) == 0)
						add_txt(csvt_pkg::CH_CR);
					add_txt(csvt_pkg::CH_LF);
				end
			end
		end
		if (txt_q.size() == start)
			add_txt("a");
		txt_q[txt_q.size() - 1].eob = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Directed table. Rows that read off plainly are pinned; the rest go
	// through the predictor. The colour code holds its reset value here.
	// ------------------------------------------------------------------
	row_t dir_tab [0:27];

	initial begin
		dir_tab = '{
			// A single byte on the last item: the byte, then the row mark.
			'{8'h41, 1'b1, 1'b1, 2'd2,
				'{csvt_pkg::KIND_BYTE, 8'h41, 1'b0},
				'{csvt_pkg::KIND_ROW, 8'd0, 1'b1}, NO_TOK},
			'{8'hFF, 1'b1, 1'b1, 2'd2,
				'{csvt_pkg::KIND_BYTE, 8'hFF, 1'b0},
				'{csvt_pkg::KIND_ROW, 8'd0, 1'b1}, NO_TOK},
			// A raw zero gives no byte, yet the cell counts as present.
			'{csvt_pkg::CH_NUL, 1'b1, 1'b1, 2'd1,
				'{csvt_pkg::KIND_ROW, 8'd0, 1'b1}, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_LOW_C, 1'b0, 1'b1, 2'd1,
				'{csvt_pkg::KIND_BYTE, csvt_pkg::COLOR_CODE_RESET, 1'b1}, NO_TOK, NO_TOK},
			// Open hex escape at the end of a cell, then the flush: three tokens.
			'{csvt_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_LOW_X, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{8'h35, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_COMMA, 1'b1, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			// Quoted cell with a doubled quote, closed by a pending quote and a CR.
			'{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{8'h61, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_CR, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			// Stray quote in a cell that already has content.
			'{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			// Hex escape cut short by a non-hex byte.
			'{csvt_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_LOW_X, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{8'h37, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{8'h7A, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			// Raw zero truncates the cell; the following byte is silent.
			'{csvt_pkg::CH_NUL, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{8'h71, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_COMMA, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			// Trailing lone backslash, dropped as the row ends.
			'{csvt_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_LF, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			// Quote on the last item closes the quotes at once.
			'{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{8'h62, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK},
			'{csvt_pkg::CH_QUOTE, 1'b1, 1'b0, 2'd0, NO_TOK, NO_TOK, NO_TOK}
		};
	end

	// ------------------------------------------------------------------
	// Receiver: ready follows a rotating pattern, reloaded when rdy_cnt wraps.
	// Some reloads are all ones for stretches without stalls; the others
	// keep bit 0 set so every turn of the pattern raises ready at least once.
	// ------------------------------------------------------------------
	logic [15:0] rdy_pat;
	int          rdy_cnt;

	always @(posedge clk) begin
		if (!arst_n) begin
			tok_out.ready <= 1'b0;
			rdy_pat       <= 16'hFFFF;
			rdy_cnt       <= 0;
		end else begin
			if (rdy_cnt == 63) begin
				rdy_cnt <= 0;
				if ($urandom_range(0, 3) == 0)
					rdy_pat <= 16'hFFFF;
				else
					rdy_pat <= 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
			end else begin
				rdy_cnt <= rdy_cnt + 1;
				rdy_pat <= {rdy_pat[0], rdy_pat[15:1]};
			end
			tok_out.ready <= rdy_pat[0];
		end
	end

	// ------------------------------------------------------------------
	// Token checker: every accepted token is matched against the oldest one
	// awaited.
	// ------------------------------------------------------------------
	tok_t got_tok;
	tok_t exp_tok;

	always @(posedge clk) begin
		if (arst_n && tok_out.valid && tok_out.ready) begin
			got_tok.kind = tok_out.item_kind;
			got_tok.data = tok_out.cell_byte;
			got_tok.last = tok_out.last_of_run;
			if (tok_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected token: kind %0d byte %02h last %0b",
						got_tok.kind, got_tok.data, got_tok.last);
			end else begin
				exp_tok = tok_expected.pop_front();
				if (got_tok.kind !== exp_tok.kind || got_tok.data !== exp_tok.data ||
						got_tok.last !== exp_tok.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("token mismatch: expected %0d %02h %0b, got %0d %02h %0b",
							exp_tok.kind, exp_tok.data, exp_tok.last,
							got_tok.kind, got_tok.data, got_tok.last);
				end
			end
		end
	end

	// Watchdog: ends the run if neither channel moves an item for too long.
	int idle_cycles;

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((txt_in.valid && txt_in.ready) || (tok_out.valid && tok_out.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[csv_tokenizer_with_escapes] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, directed table, then random phases at several
	// colour code settings, the extremes among them.
	// ------------------------------------------------------------------
	logic [7:0] phase_codes [4];
	row_t       rnd_row;
	txt_t       next_txt;

	initial begin
		burst_left   = 0;
		colour_code  = csvt_pkg::COLOR_CODE_RESET;
		clear_tokenizer();
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= 8'd0;
		txt_in.valid         <= 1'b0;
		txt_in.text_byte     <= 8'd0;
		txt_in.end_of_buffer <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 28; i++)
			feed_row(dir_tab[i]);
		drain_tokenizer();

		phase_codes[0] = 8'h00;
		phase_codes[1] = 8'hFF;
		phase_codes[2] = 8'($urandom_range(1, 254));
		phase_codes[3] = 8'($urandom_range(0, 255));

		for (int p = 0; p < 4; p++) begin
			write_colour_code(phase_codes[p]);
			while (txt_q.size() < ITEMS_PER_PHASE)
				gen_buffer();
			while (txt_q.size() != 0) begin
				next_txt         = txt_q.pop_front();
				rnd_row          = '0;
				rnd_row.txt      = next_txt.txt;
				rnd_row.eob      = next_txt.eob;
				feed_row(rnd_row);
			end
			drain_tokenizer();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && tok_expected.size() == 0) begin
			$display("[csv_tokenizer_with_escapes] OK");
		end else begin
			$display("[csv_tokenizer_with_escapes] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/csvt_pkg.sv
hw/rtl/csvt_in_if.sv
hw/rtl/csvt_out_if.sv
hw/rtl/csvt_front.sv
hw/rtl/csvt_queue.sv
hw/rtl/csvt_back.sv
hw/rtl/csv_tokenizer_with_escapes.sv
dv/tb_top.sv
